[design/sscnt_pkg.sv]
// ----------------------------------------------------------------------------
// Selector specificity counter package
// Shared constants, types and byte classification functions.
// ----------------------------------------------------------------------------
package sscnt_pkg;

   // Default width of the internal saturating counters
   localparam int COUNT_WIDTH_DEFAULT = 8;
   // Width of each count on the result channel
   localparam int OUT_WIDTH           = 8;

   // Characters of interest
   localparam logic [7:0] CHR_HASH      = 8'h23; // '#'
   localparam logic [7:0] CHR_LBRACKET  = 8'h5B; // '['
   localparam logic [7:0] CHR_RBRACKET  = 8'h5D; // ']'
   localparam logic [7:0] CHR_DOT       = 8'h2E; // '.'
   localparam logic [7:0] CHR_COLON     = 8'h3A; // ':'
   localparam logic [7:0] CHR_GT        = 8'h3E; // '>'
   localparam logic [7:0] CHR_PLUS      = 8'h2B; // '+'
   localparam logic [7:0] CHR_TILDE     = 8'h7E; // '~'
   localparam logic [7:0] CHR_COMMA     = 8'h2C; // ','
   localparam logic [7:0] CHR_BACKSLASH = 8'h5C; // '\'
   localparam logic [7:0] CHR_DQUOTE    = 8'h22; // '"'
   localparam logic [7:0] CHR_SQUOTE    = 8'h27; // '''
   localparam logic [7:0] CHR_SPACE     = 8'h20;
   localparam logic [7:0] CHR_TAB       = 8'h09;
   localparam logic [7:0] CHR_CR        = 8'h0D;

   // Quoting state
   typedef enum logic [1:0] {
      QUOTE_NONE   = 2'd0,
      QUOTE_DOUBLE = 2'd1,
      QUOTE_SINGLE = 2'd2
   } quote_type;

   // One selector byte as held in the input register
   typedef struct packed {
      logic [7:0] sel_byte;
      logic       is_last;
   } req_item_type;

   // Space, tab, LF, VT, FF or CR
   function automatic logic is_space(input logic [7:0] b);
      return (b == CHR_SPACE) || ((b >= CHR_TAB) && (b <= CHR_CR));
   endfunction

   // ASCII letter A-Z or a-z
   function automatic logic is_letter(input logic [7:0] b);
      return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
   endfunction

   // Byte after which a letter starts a type selector
   function automatic logic is_combinator(input logic [7:0] b);
      return is_space(b) || (b == CHR_GT) || (b == CHR_PLUS) ||
             (b == CHR_TILDE) || (b == CHR_COMMA);
   endfunction

endpackage

[design/sscnt_if.sv]
// ----------------------------------------------------------------------------
// Selector specificity counter channels
// Valid/ready channels for selector bytes and for count results.
// ----------------------------------------------------------------------------

// Selector byte channel
interface sscnt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] sel_byte;
   logic       is_last;

   modport source (output valid, output sel_byte, output is_last, input ready);
   modport sink   (input valid, input sel_byte, input is_last, output ready);
endinterface

// Count result channel
interface sscnt_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [sscnt_pkg::OUT_WIDTH-1:0] id_count;
   logic [sscnt_pkg::OUT_WIDTH-1:0] class_count;
   logic [sscnt_pkg::OUT_WIDTH-1:0] element_count;

   modport source (output valid, output id_count, output class_count,
                   output element_count, input ready);
   modport sink   (input valid, input id_count, input class_count,
                   input element_count, output ready);
endinterface

[design/sscnt_in_reg.sv]
// ----------------------------------------------------------------------------
// Selector byte input register
// Captures one byte per transfer; frees as soon as the parser takes it.
// ----------------------------------------------------------------------------
module sscnt_in_reg (
   input  logic                    clock,
   input  logic                    reset,
   sscnt_req_if.sink               req_chan,
   input  logic                    advance,
   output logic                    item_valid,
   output sscnt_pkg::req_item_type item
);

   logic                    valid_ff;
   logic                    valid_in;
   sscnt_pkg::req_item_type item_ff;
   logic                    take;

   // Ready whenever the register is empty or drains this cycle
   assign req_chan.ready = !valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.sel_byte <= req_chan.sel_byte;
         item_ff.is_last  <= req_chan.is_last;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[design/sscnt_parser.sv]
// ----------------------------------------------------------------------------
// Selector specificity parser
// Scan state and saturating counters, updated once per selector byte.
// ----------------------------------------------------------------------------
module sscnt_parser #(
   parameter int COUNT_WIDTH = sscnt_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_valid,
   input  sscnt_pkg::req_item_type item,
   input  logic                    slot_free,
   output logic                    advance,
   output logic                    rsp_load,
   output logic [COUNT_WIDTH-1:0]  ids_out,
   output logic [COUNT_WIDTH-1:0]  classes_out,
   output logic [COUNT_WIDTH-1:0]  elements_out
);

   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

   sscnt_pkg::quote_type   quote_ff, quote_in;
   logic                   attr_ff, attr_in;
   logic                   esc_ff, esc_in;
   logic                   colon_ff, colon_in;
   logic [7:0]             prev_ff, prev_in;
   logic                   start_ff, start_in;
   logic [COUNT_WIDTH-1:0] ids_ff, ids_in;
   logic [COUNT_WIDTH-1:0] cls_ff, cls_in;
   logic [COUNT_WIDTH-1:0] els_ff, els_in;

   logic                   inc_id;
   logic [1:0]             inc_cls;
   logic                   inc_el;
   logic [COUNT_WIDTH:0]   cls_sum;
   logic [7:0]             b;
   logic                   last;
   logic                   consumed;

   // A final byte waits for a free result slot; others always move on
   assign advance  = item_valid && (!item.is_last || slot_free);
   assign rsp_load = advance && item.is_last;
   assign b        = item.sel_byte;
   assign last     = item.is_last;

   // Byte classification
   always_comb begin
      quote_in = quote_ff;
      attr_in  = attr_ff;
      esc_in   = esc_ff;
      colon_in = colon_ff;
      inc_id   = 1'b0;
      inc_cls  = 2'd0;
      inc_el   = 1'b0;
      consumed = 1'b0;

      if (esc_ff) begin
         esc_in = 1'b0;
      end else if (quote_ff != sscnt_pkg::QUOTE_NONE) begin
         if ((b == sscnt_pkg::CHR_BACKSLASH) && !last) begin
            esc_in = 1'b1;
         end else if (((quote_ff == sscnt_pkg::QUOTE_SINGLE) &&
                       (b == sscnt_pkg::CHR_SQUOTE)) ||
                      ((quote_ff != sscnt_pkg::QUOTE_SINGLE) &&
                       (b == sscnt_pkg::CHR_DQUOTE))) begin
            quote_in = sscnt_pkg::QUOTE_NONE;
         end
      end else begin
         // Colon held from the previous byte: pseudo-element or pseudo-class
         if (colon_ff) begin
            colon_in = 1'b0;
            if (b == sscnt_pkg::CHR_COLON) begin
               inc_el   = 1'b1;
               consumed = 1'b1;
            end else begin
               inc_cls = 2'd1;
            end
         end
         if (!consumed) begin
            if (b == sscnt_pkg::CHR_DQUOTE) begin
               quote_in = sscnt_pkg::QUOTE_DOUBLE;
            end else if (b == sscnt_pkg::CHR_SQUOTE) begin
               quote_in = sscnt_pkg::QUOTE_SINGLE;
            end else if (b == sscnt_pkg::CHR_LBRACKET) begin
               attr_in = 1'b1;
               inc_cls = inc_cls + 2'd1;
            end else if (b == sscnt_pkg::CHR_RBRACKET) begin
               attr_in = 1'b0;
            end else if (!attr_ff) begin
               if (b == sscnt_pkg::CHR_HASH) begin
                  inc_id = 1'b1;
               end else if (b == sscnt_pkg::CHR_DOT) begin
                  inc_cls = inc_cls + 2'd1;
               end else if (b == sscnt_pkg::CHR_COLON) begin
                  if (last) begin
                     inc_cls = inc_cls + 2'd1;
                  end else begin
                     colon_in = 1'b1;
                  end
               end else if (sscnt_pkg::is_letter(b) &&
                            (start_ff || sscnt_pkg::is_combinator(prev_ff))) begin
                  inc_el = 1'b1;
               end
            end
         end
      end
   end

   // Saturating counter updates
   always_comb begin
      ids_in  = (inc_id && (ids_ff != CNT_MAX)) ? ids_ff + 1'b1 : ids_ff;
      els_in  = (inc_el && (els_ff != CNT_MAX)) ? els_ff + 1'b1 : els_ff;
      cls_sum = {1'b0, cls_ff} + (COUNT_WIDTH+1)'(inc_cls);
      cls_in  = (cls_sum > {1'b0, CNT_MAX}) ? CNT_MAX : cls_sum[COUNT_WIDTH-1:0];
      prev_in  = b;
      start_in = 1'b0;
   end

   assign ids_out      = ids_in;
   assign classes_out  = cls_in;
   assign elements_out = els_in;

   // State update; a final byte returns everything to reset values
   always_ff @(posedge clock) begin
      if (reset || rsp_load) begin
         quote_ff <= sscnt_pkg::QUOTE_NONE;
         attr_ff  <= 1'b0;
         esc_ff   <= 1'b0;
         colon_ff <= 1'b0;
         prev_ff  <= 8'd0;
         start_ff <= 1'b1;
         ids_ff   <= '0;
         cls_ff   <= '0;
         els_ff   <= '0;
      end else if (advance) begin
         quote_ff <= quote_in;
         attr_ff  <= attr_in;
         esc_ff   <= esc_in;
         colon_ff <= colon_in;
         prev_ff  <= prev_in;
         start_ff <= start_in;
         ids_ff   <= ids_in;
         cls_ff   <= cls_in;
         els_ff   <= els_in;
      end
   end

endmodule

[design/sscnt_rsp_reg.sv]
// ----------------------------------------------------------------------------
// Selector specificity result register
// Holds the clamped counts of one selector until the transfer completes.
// ----------------------------------------------------------------------------
module sscnt_rsp_reg #(
   parameter int COUNT_WIDTH = sscnt_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  logic [COUNT_WIDTH-1:0] ids,
   input  logic [COUNT_WIDTH-1:0] classes,
   input  logic [COUNT_WIDTH-1:0] elements,
   output logic                   slot_free,
   sscnt_rsp_if.source            rsp_chan
);

   localparam int OW = sscnt_pkg::OUT_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] OUT_LIMIT = COUNT_WIDTH'((1 << OW) - 1);

   logic          valid_ff, valid_in;
   logic [OW-1:0] id_ff, cls_ff, el_ff;

   // Clamp a count to the result field width
   function automatic logic [OW-1:0] clamp(input logic [COUNT_WIDTH-1:0] c);
      return (c > OUT_LIMIT) ? {OW{1'b1}} : OW'(c);
   endfunction

   assign slot_free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      if (load) begin
         id_ff  <= clamp(ids);
         cls_ff <= clamp(classes);
         el_ff  <= clamp(elements);
      end
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.id_count      = id_ff;
   assign rsp_chan.class_count   = cls_ff;
   assign rsp_chan.element_count = el_ff;

endmodule

[design/selector_specificity_counter_core.sv]
// ----------------------------------------------------------------------------
// Selector specificity counter
// Counts id, class and element parts of a selector streamed byte by byte.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one selector byte per transfer, with is_last set on the
//   final byte. rsp_chan carries one result (id, class and element counts)
//   per selector, produced only for the final byte; other bytes give none.
//   Quoted text and attribute bodies are skipped as in the selector grammar.
// Timing:
//   One byte is taken every cycle, except while a final byte waits for a
//   free result slot. A byte is held in the input register, is parsed and
//   the counts are updated, and the final byte's counts are then loaded into
//   the result register, which drives rsp_chan. The parse logic between the
//   two registers is combinational, so bytes keep flowing while no final
//   byte waits.
// Reset and stalls:
//   reset clears the scan state, counters and both valid flags. While a
//   result waits on rsp_chan, non-final bytes still flow; a final byte waits
//   in the input register until the result slot frees, and req_chan.ready
//   drops only then. Counts saturate and return to zero after each result.
// ----------------------------------------------------------------------------
module selector_specificity_counter_core #(
   parameter int COUNT_WIDTH = sscnt_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   sscnt_req_if.sink   req_chan,
   sscnt_rsp_if.source rsp_chan
);

   logic                    item_valid;
   sscnt_pkg::req_item_type item;
   logic                    advance;
   logic                    rsp_load;
   logic                    slot_free;
   logic [COUNT_WIDTH-1:0]  ids;
   logic [COUNT_WIDTH-1:0]  classes;
   logic [COUNT_WIDTH-1:0]  elements;

   // Input register
   sscnt_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   // Scan state and counters
   sscnt_parser #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (item_valid),
      .item         (item),
      .slot_free    (slot_free),
      .advance      (advance),
      .rsp_load     (rsp_load),
      .ids_out      (ids),
      .classes_out  (classes),
      .elements_out (elements)
   );

   // Result register
   sscnt_rsp_reg #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (rsp_load),
      .ids       (ids),
      .classes   (classes),
      .elements  (elements),
      .slot_free (slot_free),
      .rsp_chan  (rsp_chan)
   );

endmodule

[design/sscnt_checker.sv]
// ----------------------------------------------------------------------------
// Selector specificity counter checker
// Port-level properties of the counter, bound to the top level.
// ----------------------------------------------------------------------------
module sscnt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [sscnt_pkg::OUT_WIDTH-1:0] id_count,
   input logic [sscnt_pkg::OUT_WIDTH-1:0] class_count,
   input logic [sscnt_pkg::OUT_WIDTH-1:0] element_count
);

   // Reset empties the result register
   a_reset_clears : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // With the result slot free, bytes are never back-pressured
   a_ready_when_free : assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("input stalled while result slot free");

   // A stalled result holds its counts
   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(id_count) && $stable(class_count) &&
          $stable(element_count)))
      else $error("result changed during stall");

endmodule

bind selector_specificity_counter_core sscnt_checker u_sscnt_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .id_count      (rsp_chan.id_count),
   .class_count   (rsp_chan.class_count),
   .element_count (rsp_chan.element_count)
);

[tb/sv/sscnt_count_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selector specificity count checker
// Watches both channels of the counter, keeps its own copy of the scan state,
// works out the counts due for each selector and compares every result
// transfer, field by field, with the oldest count set still waiting.
// ----------------------------------------------------------------------------
module sscnt_count_check (
   input  logic  clock,
   input  logic  reset,
   sscnt_req_if  req_mon,
   sscnt_rsp_if  rsp_mon,
   output int    fail_count,
   output int    outstanding
);

   localparam int CNT_W = sscnt_pkg::COUNT_WIDTH_DEFAULT;

   typedef logic [CNT_W-1:0]                cnt_type;
   typedef logic [sscnt_pkg::OUT_WIDTH-1:0] out_type;

   typedef struct packed {
      out_type ids;
      out_type classes;
      out_type elems;
   } counts_type;

   // Count sets for selectors whose final byte has gone in
   counts_type due_counts[$];
   int         n_fail = 0;
   int         n_due  = 0;

   // Scan state
   sscnt_pkg::quote_type quote_st;
   logic                 in_attr;
   logic                 esc_pend;
   logic                 colon_pend;
   logic                 first_chr;
   logic [7:0]           prev_chr;
   cnt_type              n_ids;
   cnt_type              n_classes;
   cnt_type              n_elems;

   assign fail_count  = n_fail;
   assign outstanding = n_due;

   function automatic cnt_type sat_inc(input cnt_type c);
      return (&c) ? c : c + 1'b1;
   endfunction

   function automatic out_type clamp_count(input cnt_type c);
      if (int'(c) > (1 << sscnt_pkg::OUT_WIDTH) - 1) return '1;
      return out_type'(c);
   endfunction

   // A letter after one of these starts a type selector
   function automatic logic opens_type(input logic [7:0] p);
      return (p == sscnt_pkg::CHR_SPACE) ||
             ((p >= sscnt_pkg::CHR_TAB) && (p <= sscnt_pkg::CHR_CR)) ||
             (p == sscnt_pkg::CHR_GT) || (p == sscnt_pkg::CHR_PLUS) ||
             (p == sscnt_pkg::CHR_TILDE) || (p == sscnt_pkg::CHR_COMMA);
   endfunction

   function automatic logic alpha(input logic [7:0] b);
      return ((b >= "A") && (b <= "Z")) || ((b >= "a") && (b <= "z"));
   endfunction

   task automatic clear_scan();
      quote_st   = sscnt_pkg::QUOTE_NONE;
      in_attr    = 1'b0;
      esc_pend   = 1'b0;
      colon_pend = 1'b0;
      first_chr  = 1'b1;
      prev_chr   = '0;
      n_ids      = '0;
      n_classes  = '0;
      n_elems    = '0;
   endtask

   task automatic report_mismatch(input string msg);
      $display("[%0t] count_check: %s", $time, msg);
      n_fail++;
   endtask

   // Effect of one byte on the counts; prev/first describe the byte before
   task automatic apply_byte(input logic [7:0] b, input logic last,
                             input logic [7:0] prev, input logic first);
      logic [7:0] close_q;
      if (esc_pend) begin
         esc_pend = 1'b0;
         return;
      end
      // quoted text: only the closing quote and escapes matter
      if (quote_st != sscnt_pkg::QUOTE_NONE) begin
         close_q = (quote_st == sscnt_pkg::QUOTE_SINGLE) ? sscnt_pkg::CHR_SQUOTE
                                                         : sscnt_pkg::CHR_DQUOTE;
         if ((b == sscnt_pkg::CHR_BACKSLASH) && !last) esc_pend = 1'b1;
         else if (b == close_q) quote_st = sscnt_pkg::QUOTE_NONE;
         return;
      end
      // held colon: a second colon makes a pseudo-element
      if (colon_pend) begin
         colon_pend = 1'b0;
         if (b == sscnt_pkg::CHR_COLON) begin
            n_elems = sat_inc(n_elems);
            return;
         end
         n_classes = sat_inc(n_classes);
      end
      case (b)
         sscnt_pkg::CHR_DQUOTE:   quote_st = sscnt_pkg::QUOTE_DOUBLE;
         sscnt_pkg::CHR_SQUOTE:   quote_st = sscnt_pkg::QUOTE_SINGLE;
         sscnt_pkg::CHR_LBRACKET: begin
            in_attr   = 1'b1;
            n_classes = sat_inc(n_classes);
         end
         sscnt_pkg::CHR_RBRACKET: in_attr = 1'b0;
         default: begin
            if (!in_attr) begin
               if (b == sscnt_pkg::CHR_HASH) n_ids = sat_inc(n_ids);
               else if (b == sscnt_pkg::CHR_DOT) n_classes = sat_inc(n_classes);
               else if (b == sscnt_pkg::CHR_COLON) begin
                  if (last) n_classes = sat_inc(n_classes);
                  else colon_pend = 1'b1;
               end else if (alpha(b) && (first || opens_type(prev))) begin
                  n_elems = sat_inc(n_elems);
               end
            end
         end
      endcase
   endtask

   task automatic scan_byte(input logic [7:0] b, input logic last);
      logic [7:0] prev;
      logic       first;
      counts_type item_counts;
      prev      = prev_chr;
      first     = first_chr;
      first_chr = 1'b0;
      prev_chr  = b;
      apply_byte(b, last, prev, first);
      if (last) begin
         item_counts.ids     = clamp_count(n_ids);
         item_counts.classes = clamp_count(n_classes);
         item_counts.elems   = clamp_count(n_elems);
         due_counts.insert(due_counts.size(), item_counts);
         clear_scan();
      end
   endtask

   task automatic check_result();
      counts_type want;
      if (due_counts.size() == 0) begin
         report_mismatch($sformatf("result %0d/%0d/%0d with no selector pending",
                                   rsp_mon.id_count, rsp_mon.class_count,
                                   rsp_mon.element_count));
         return;
      end
      want = due_counts.pop_front();
      if (rsp_mon.id_count !== want.ids)
         report_mismatch($sformatf("id_count %0d, expected %0d",
                                   rsp_mon.id_count, want.ids));
      if (rsp_mon.class_count !== want.classes)
         report_mismatch($sformatf("class_count %0d, expected %0d",
                                   rsp_mon.class_count, want.classes));
      if (rsp_mon.element_count !== want.elems)
         report_mismatch($sformatf("element_count %0d, expected %0d",
                                   rsp_mon.element_count, want.elems));
   endtask

   // Sample both channels at each rising edge
   always @(posedge clock) begin
      if (reset) begin
         clear_scan();
         due_counts.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            scan_byte(req_mon.sel_byte, req_mon.is_last);
         if (rsp_mon.valid && rsp_mon.ready)
            check_result();
      end
      n_due = due_counts.size();
   end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selector specificity counter testbench
// Streams directed and random selectors into the counter with random gaps
// on both channels, holds the result side off for long stretches, and
// reports the verdict from the checker's mismatch and outstanding counts.
// ----------------------------------------------------------------------------
module tb;

   localparam int  TOTAL_BYTES     = 1700;
   localparam int  SAT_REPEATS     = 260;
   localparam int  RSP_HOLD_CYCLES = 300;
   localparam int  DRAIN_LIMIT     = 2000;
   localparam longint TIMEOUT_NS   = 64'd8_000_000;

   logic clock;
   logic reset;
   int   fail_count;
   int   outstanding;

   // Selector being assembled for the next burst of transfers
   logic [7:0] sel_buf[$];
   bit         hold_rsp    = 1'b0;
   bit         rsp_holding = 1'b0;
   int         sent_bytes  = 0;

   sscnt_req_if req_chan ();
   sscnt_rsp_if rsp_chan ();

   selector_specificity_counter_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   sscnt_count_check count_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #(TIMEOUT_NS);
      $display("** selector_specificity_counter_core: FAILED **");
      $finish;
   end

   // Mostly short gaps, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic push_byte(input logic [7:0] b);
      sel_buf.insert(sel_buf.size(), b);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endtask

   task automatic push_word();
      int n;
      n = $urandom_range(1, 5);
      repeat (n) begin
         case ($urandom_range(0, 7))
            0:       push_byte(8'h30 + 8'($urandom_range(0, 9)));
            1:       push_byte(8'h2D);
            2, 3:    push_byte(8'h41 + 8'($urandom_range(0, 25)));
            default: push_byte(8'h61 + 8'($urandom_range(0, 25)));
         endcase
      end
   endtask

   task automatic push_combinator();
      case ($urandom_range(0, 9))
         0:       push_byte(sscnt_pkg::CHR_TAB);
         1:       push_byte(8'h0A);
         2:       push_byte(8'h0B);
         3:       push_byte(8'h0C);
         4:       push_byte(sscnt_pkg::CHR_CR);
         5:       push_byte(sscnt_pkg::CHR_GT);
         6:       push_byte(sscnt_pkg::CHR_PLUS);
         7:       push_byte(sscnt_pkg::CHR_TILDE);
         8:       push_byte(sscnt_pkg::CHR_COMMA);
         default: push_byte(sscnt_pkg::CHR_SPACE);
      endcase
   endtask

   // Any byte, half the time one at a class boundary
   task automatic push_noise();
      if ($urandom_range(0, 1) == 0) begin
         push_byte(8'($urandom_range(0, 255)));
      end else begin
         case ($urandom_range(0, 14))
            0:       push_byte(8'h00);
            1:       push_byte(8'h08);
            2:       push_byte(8'h0E);
            3:       push_byte(8'h1F);
            4:       push_byte(8'h21);
            5:       push_byte(8'h40);
            6:       push_byte(8'h5B);
            7:       push_byte(sscnt_pkg::CHR_RBRACKET);
            8:       push_byte(8'h60);
            9:       push_byte(8'h7B);
            10:      push_byte(8'h7F);
            11:      push_byte(8'h80);
            12:      push_byte(sscnt_pkg::CHR_BACKSLASH);
            13:      push_byte(sscnt_pkg::CHR_COLON);
            default: push_byte(8'hFF);
         endcase
      end
   endtask

   // Quoted string with escapes and the other quote inside
   task automatic push_quoted();
      logic [7:0] q;
      int         n;
      q = ($urandom_range(0, 1) == 0) ? sscnt_pkg::CHR_DQUOTE : sscnt_pkg::CHR_SQUOTE;
      n = $urandom_range(0, 5);
      push_byte(q);
      repeat (n) begin
         case ($urandom_range(0, 4))
            0: push_byte((q == sscnt_pkg::CHR_DQUOTE) ? sscnt_pkg::CHR_SQUOTE
                                                      : sscnt_pkg::CHR_DQUOTE);
            1: begin
               push_byte(sscnt_pkg::CHR_BACKSLASH);
               if ($urandom_range(0, 1) == 0) push_byte(q);
               else push_noise();
            end
            2: push_noise();
            default: push_word();
         endcase
      end
      if ($urandom_range(0, 7) != 0) push_byte(q);
   endtask

   task automatic add_token();
      case ($urandom_range(0, 11))
         0, 1: push_word();
         2: begin
            push_byte(sscnt_pkg::CHR_HASH);
            push_word();
         end
         3: begin
            push_byte(sscnt_pkg::CHR_DOT);
            push_word();
         end
         4: begin
            push_byte(sscnt_pkg::CHR_COLON);
            push_word();
         end
         5: begin
            push_byte(sscnt_pkg::CHR_COLON);
            push_byte(sscnt_pkg::CHR_COLON);
            push_word();
         end
         6: begin
            push_byte(sscnt_pkg::CHR_LBRACKET);
            push_word();
            if ($urandom_range(0, 1) == 0) begin
               push_text("=");
               push_quoted();
            end
            if ($urandom_range(0, 7) != 0) push_byte(sscnt_pkg::CHR_RBRACKET);
         end
         7, 8: push_combinator();
         9:    push_quoted();
         default: push_noise();
      endcase
   endtask

   // Mostly well-formed selectors, some noise and some cut short
   task automatic build_random_selector();
      int n_tok;
      int keep;
      if ($urandom_range(0, 9) == 0) begin
         n_tok = $urandom_range(1, 8);
         repeat (n_tok) push_noise();
      end else begin
         n_tok = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                              : $urandom_range(1, 6);
         repeat (n_tok) add_token();
         if ($urandom_range(0, 4) == 0) begin
            keep = $urandom_range(1, sel_buf.size());
            while (sel_buf.size() > keep) sel_buf.delete(sel_buf.size() - 1);
         end
      end
   endtask

   // One byte transfer; valid stays high until the next call or a pause
   task automatic send_byte(input logic [7:0] b, input logic last, input bit gaps);
      int gap;
      gap = gaps ? idle_len() : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.sel_byte <= b;
      req_chan.is_last  <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent_bytes++;
   endtask

   task automatic send_selector(input bit allow_gaps);
      bit gaps;
      gaps = allow_gaps && ($urandom_range(0, 3) != 0);
      for (int i = 0; i < sel_buf.size(); i++)
         send_byte(sel_buf[i], i == sel_buf.size() - 1, gaps);
      sel_buf.delete();
   endtask

   task automatic wait_drained();
      int w;
      req_chan.valid <= 1'b0;
      @(posedge clock);
      for (w = 0; (w < DRAIN_LIMIT) && (outstanding != 0); w++) @(posedge clock);
   endtask

   // Receiver holds off while selectors keep coming, so the input backs up
   task automatic flood_under_hold();
      req_chan.valid <= 1'b0;
      hold_rsp = 1'b1;
      do @(posedge clock); while (!rsp_holding);
      repeat (6) begin
         build_random_selector();
         send_selector(1'b0);
      end
   endtask

   // Result side: random ready pattern, long holds on request
   initial begin
      int n;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp       = 1'b0;
            rsp_holding    = 1'b1;
            rsp_chan.ready <= 1'b0;
            for (n = 0; n < RSP_HOLD_CYCLES; n++) @(posedge clock);
            rsp_holding = 1'b0;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b0;
            n = idle_len();
            repeat ((n == 0) ? 1 : n) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                           : $urandom_range(1, 12);
            repeat (n) @(posedge clock);
         end
      end
   end

   // Stimulus and verdict
   initial begin
      req_chan.valid    <= 1'b0;
      req_chan.sel_byte <= '0;
      req_chan.is_last  <= 1'b0;
      reset             <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // single bytes: letter, id, lone colon on the final byte, both extremes
      push_text("a");             send_selector(1'b1);
      push_text("#");             send_selector(1'b1);
      push_text(":");             send_selector(1'b1);
      push_byte(8'h00);           send_selector(1'b1);
      push_byte(8'hFF);           send_selector(1'b1);
      // pseudo-element against pseudo-class, colon before other bytes
      push_text("a::before");     send_selector(1'b1);
      push_text("a:hover");       send_selector(1'b1);
      push_text(":::");           send_selector(1'b1);
      push_text("a:#b");          send_selector(1'b1);
      push_text(":\"x\"");        send_selector(1'b1);
      push_text(":[y]");          send_selector(1'b1);
      // combinators and quoting
      push_text("div > p + span ~ em, h1 b"); send_selector(1'b1);
      push_text("[x=\"a]b\"]c");  send_selector(1'b1);
      push_text("'a\\'b'#x");     send_selector(1'b1);
      push_text("\"q\\");         send_selector(1'b1);
      push_text("'\\");           send_selector(1'b1);
      push_text("\"\\\"");        send_selector(1'b1);
      push_text("\\a");           send_selector(1'b1);
      push_text("x\"#");          send_selector(1'b1);
      push_text("[abc.d");        send_selector(1'b1);
      push_text("]a.b");          send_selector(1'b1);
      // letter range edges after a space
      push_text(" @ ` { A Z a z"); send_selector(1'b1);
      // every whitespace code and its neighbours before a letter
      push_byte(8'h08); push_text("a"); push_byte(sscnt_pkg::CHR_TAB); push_text("a");
      push_byte(8'h0A); push_text("a"); push_byte(8'h0B); push_text("a");
      push_byte(8'h0C); push_text("a"); push_byte(sscnt_pkg::CHR_CR); push_text("a");
      push_byte(8'h0E); push_text("a"); push_byte(8'h1F); push_text("a");
      push_byte(sscnt_pkg::CHR_SPACE); push_text("a"); push_byte(8'h21); push_text("a");
      send_selector(1'b1);
      // all three counts driven past saturation; classes cross it two at once
      repeat (SAT_REPEATS) push_byte(sscnt_pkg::CHR_HASH);
      repeat (253) push_byte(sscnt_pkg::CHR_DOT);
      repeat (3) push_text(":[]");
      repeat (SAT_REPEATS) begin
         push_byte(sscnt_pkg::CHR_SPACE);
         push_text("a");
      end
      send_selector(1'b1);

      wait_drained();
      flood_under_hold();
      wait_drained();

      // random selectors, with the odd long hold or full drain
      while (sent_bytes < TOTAL_BYTES) begin
         if ($urandom_range(0, 59) == 0) flood_under_hold();
         else if ($urandom_range(0, 39) == 0) wait_drained();
         build_random_selector();
         send_selector(1'b1);
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if ((fail_count == 0) && (outstanding == 0)) begin
         $display("** selector_specificity_counter_core: PASSED **");
      end else begin
         $display("** selector_specificity_counter_core: FAILED **");
      end
      $finish;
   end

endmodule

[filelist.f]
design/sscnt_pkg.sv
design/sscnt_if.sv
design/sscnt_in_reg.sv
design/sscnt_parser.sv
design/sscnt_rsp_reg.sv
design/selector_specificity_counter_core.sv
design/sscnt_checker.sv
tb/sv/sscnt_count_check.sv
tb/sv/tb.sv
